@@ hw/rtl/slpq_pkg.sv @@
// Shared types and codes for the sorted list priority queue.
package slpq_pkg;

   // Operation codes on req_func
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_ERASE  = 2'd1;
   localparam logic [1:0] OP_POP    = 2'd2;

   // Status codes on rsp_status
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_FULL    = 2'd1;
   localparam logic [1:0] STAT_MISSING = 2'd2;
   localparam logic [1:0] STAT_EMPTY   = 2'd3;

   // Port field widths
   localparam int KEY_PORT_BITS   = 16;
   localparam int COUNT_PORT_BITS = 5;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_EXEC = 4'b0100,
      S_HEAD = 4'b1000
   } slpq_state_type;

endpackage

@@ hw/rtl/slpq_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module slpq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/sorted_list_priority_queue.sv @@
// Top level of the sorted list priority queue: control sequencer around one key RAM.
//
// Keys sit in ascending order in one RAM of CAPACITY entries; the front and back
// keys and the count are kept in registers. A transaction is taken when start is
// high and busy is low, and its one result appears on the rsp_ ports for a single
// cycle with rsp_valid high; the receiver cannot stall, so it must take it then.
// An insert walks down from the back, moving each larger-or-equal key up one slot.
// An erase or pop walks the whole list once, moving keys after the match down one
// slot. An insert when full, an erase or pop when empty, and the unused code 3
// answer the cycle after acceptance. In each walk step a key is read through the
// RAM's registered read port in S_READ, then written back one slot along in S_EXEC.
// busy drops in the cycle the result is shown, so the next transaction may be
// taken in that same cycle.
module sorted_list_priority_queue
   import slpq_pkg::*;
#(
   parameter int CAPACITY = 16,
   parameter int KEY_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_func,
   input  logic [KEY_PORT_BITS-1:0]   req_key,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_status,
   output logic [KEY_PORT_BITS-1:0]   rsp_popped_key,
   output logic [KEY_PORT_BITS-1:0]   rsp_smallest,
   output logic [KEY_PORT_BITS-1:0]   rsp_largest,
   output logic [COUNT_PORT_BITS-1:0] rsp_count,
   output logic                       rsp_is_empty
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   slpq_state_type     state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic               found_ff, found_in;
   logic [KEY_BITS-1:0] prev_ff, prev_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [KEY_BITS-1:0] front_ff, front_in;
   logic [KEY_BITS-1:0] back_ff, back_in;
   logic [1:0]         status_ff, status_in;
   logic [KEY_BITS-1:0] popped_ff, popped_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [KEY_BITS-1:0] wr_data;
   logic               rd_en;
   logic [KEY_BITS-1:0] rd_data;

   logic [KEY_BITS-1:0] key_req;
   logic               last;
   logic               match;

   assign key_req = KEY_BITS'(req_key);
   assign last    = (CW'(idx_ff) == count_ff - CW'(1));
   assign match   = (op_ff == OP_POP) ? (idx_ff == '0) : (rd_data == key_ff);

   slpq_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (CAPACITY)
   ) u_keys (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      prev_in      = prev_ff;
      count_in     = count_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      status_in    = status_ff;
      popped_in    = popped_ff;
      rsp_valid_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = req_func;
               key_in    = key_req;
               found_in  = 1'b0;
               popped_in = '0;
               status_in = STAT_OK;
               idx_in    = '0;
               unique case (req_func)
                  OP_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        status_in    = STAT_FULL;
                        rsp_valid_in = 1'b1;
                     end else begin
                        if (count_ff == '0 || key_req <= front_ff) begin
                           front_in = key_req;
                        end
                        if (count_ff == '0 || key_req >= back_ff) begin
                           back_in = key_req;
                        end
                        if (count_ff == '0) begin
                           state_in = S_HEAD;
                        end else begin
                           idx_in   = AW'(count_ff - CW'(1));
                           state_in = S_READ;
                        end
                     end
                  end
                  OP_ERASE: begin
                     if (count_ff == '0) begin
                        status_in    = STAT_MISSING;
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        status_in    = STAT_EMPTY;
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (op_ff == OP_INSERT) begin
               wr_en   = 1'b1;
               wr_addr = AW'(idx_ff + AW'(1));
               if (rd_data >= key_ff) begin
                  // equal keys move up too: the new key goes before its equals
                  wr_data = rd_data;
                  if (idx_ff == '0) begin
                     state_in = S_HEAD;
                  end else begin
                     idx_in   = AW'(idx_ff - AW'(1));
                     state_in = S_READ;
                  end
               end else begin
                  wr_data      = key_ff;
                  count_in     = CW'(count_ff + CW'(1));
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               prev_in = rd_data;
               if (found_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = AW'(idx_ff - AW'(1));
                  wr_data = rd_data;
                  // a match seen before slot 1 can only have been at the front
                  if (idx_ff == AW'(1)) begin
                     front_in = rd_data;
                  end
               end else if (match) begin
                  found_in = 1'b1;
                  if (op_ff == OP_POP) begin
                     popped_in = rd_data;
                  end
                  if (last && idx_ff != '0) begin
                     back_in = prev_ff;
                  end
               end
               if (last) begin
                  if (found_ff || match) begin
                     count_in = CW'(count_ff - CW'(1));
                  end else begin
                     status_in = STAT_MISSING;
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  idx_in   = AW'(idx_ff + AW'(1));
                  state_in = S_READ;
               end
            end
         end
         S_HEAD: begin
            wr_en        = 1'b1;
            wr_addr      = '0;
            wr_data      = key_ff;
            count_in     = CW'(count_ff + CW'(1));
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      idx_ff    <= idx_in;
      prev_ff   <= prev_in;
      front_ff  <= front_in;
      back_ff   <= back_in;
      status_ff <= status_in;
      popped_ff <= popped_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_popped_key = KEY_PORT_BITS'(popped_ff);
   assign rsp_smallest   = (count_ff == '0) ? '0 : KEY_PORT_BITS'(front_ff);
   assign rsp_largest    = (count_ff == '0) ? '0 : KEY_PORT_BITS'(back_ff);
   assign rsp_count      = COUNT_PORT_BITS'(count_ff);
   assign rsp_is_empty   = (count_ff == '0);

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted transaction neither busy nor answered");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (count_ff <= CW'(CAPACITY)))
      else $error("key count beyond capacity");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) <= count_ff))
      else $error("RAM write beyond stored keys");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_FULL) |-> (count_ff == CW'(CAPACITY)))
      else $error("full status with free space");

endmodule

@@ bench/slpq_checker.sv @@
// Checker for the sorted list priority queue: predicts each transaction and compares results.
`timescale 1ns / 1ps

module slpq_checker
   import slpq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic [1:0]                 req_func,
   input  logic [KEY_PORT_BITS-1:0]   req_key,
   input  logic                       rsp_valid,
   input  logic [1:0]                 rsp_status,
   input  logic [KEY_PORT_BITS-1:0]   rsp_popped_key,
   input  logic [KEY_PORT_BITS-1:0]   rsp_smallest,
   input  logic [KEY_PORT_BITS-1:0]   rsp_largest,
   input  logic [COUNT_PORT_BITS-1:0] rsp_count,
   input  logic                       rsp_is_empty,
   output int                         fail_count,
   output int                         outstanding
);

   typedef struct packed {
      logic [1:0]                 status;
      logic [KEY_PORT_BITS-1:0]   popped_key;
      logic [KEY_PORT_BITS-1:0]   smallest;
      logic [KEY_PORT_BITS-1:0]   largest;
      logic [COUNT_PORT_BITS-1:0] count;
      logic                       is_empty;
   } queue_result_type;

   logic [KEY_PORT_BITS-1:0] sorted_keys [CAPACITY];
   int                       held_count;
   queue_result_type         expected_results [$];
   int                       txn_index;

   initial begin
      fail_count  = 0;
      outstanding = 0;
      held_count  = 0;
      txn_index   = 0;
   end

   task automatic report_error(input string msg);
      $display("[%0t] ERROR: %s", $realtime, msg);
      fail_count++;
   endtask

   // Applies one operation to the shadow list and returns the result it should give
   function automatic queue_result_type apply_queue_op(input logic [1:0] func,
                                                       input logic [KEY_PORT_BITS-1:0] key);
      queue_result_type res;
      int               pos;
      int               i;
      res        = '0;
      res.status = STAT_OK;
      case (func)
         OP_INSERT: begin
            if (held_count >= CAPACITY) begin
               res.status = STAT_FULL;
            end else begin
               pos = 0;
               while (pos < held_count && sorted_keys[pos] < key) pos++;
               for (i = held_count; i > pos; i--) sorted_keys[i] = sorted_keys[i-1];
               sorted_keys[pos] = key;
               held_count++;
            end
         end
         OP_ERASE: begin
            pos = 0;
            while (pos < held_count && sorted_keys[pos] != key) pos++;
            if (pos < held_count) begin
               for (i = pos; i + 1 < held_count; i++) sorted_keys[i] = sorted_keys[i+1];
               held_count--;
            end else begin
               res.status = STAT_MISSING;
            end
         end
         OP_POP: begin
            if (held_count == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               res.popped_key = sorted_keys[0];
               for (i = 0; i + 1 < held_count; i++) sorted_keys[i] = sorted_keys[i+1];
               held_count--;
            end
         end
         default: ; // unused code leaves the list alone
      endcase
      if (held_count > 0) begin
         res.smallest = sorted_keys[0];
         res.largest  = sorted_keys[held_count-1];
      end
      res.count    = held_count[COUNT_PORT_BITS-1:0];
      res.is_empty = (held_count == 0);
      return res;
   endfunction

   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         held_count = 0;
         expected_results.delete();
         outstanding = 0;
      end else begin
         // result first: it belongs to an earlier transaction than one taken now
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               report_error("result with no transaction outstanding");
            end else begin
               want = expected_results[0];
               expected_results.delete(0);
               txn_index++;
               if (rsp_status !== want.status)
                  report_error($sformatf("txn %0d status got %0d exp %0d",
                                         txn_index, rsp_status, want.status));
               if (rsp_popped_key !== want.popped_key)
                  report_error($sformatf("txn %0d popped_key got %h exp %h",
                                         txn_index, rsp_popped_key, want.popped_key));
               if (rsp_smallest !== want.smallest)
                  report_error($sformatf("txn %0d smallest got %h exp %h",
                                         txn_index, rsp_smallest, want.smallest));
               if (rsp_largest !== want.largest)
                  report_error($sformatf("txn %0d largest got %h exp %h",
                                         txn_index, rsp_largest, want.largest));
               if (rsp_count !== want.count)
                  report_error($sformatf("txn %0d count got %0d exp %0d",
                                         txn_index, rsp_count, want.count));
               if (rsp_is_empty !== want.is_empty)
                  report_error($sformatf("txn %0d is_empty got %b exp %b",
                                         txn_index, rsp_is_empty, want.is_empty));
            end
         end
         if (start && !busy)
            expected_results.insert(expected_results.size(),
                                    apply_queue_op(req_func, req_key));
         outstanding = expected_results.size();
      end
   end

endmodule

@@ bench/sorted_list_priority_queue_tb.sv @@
// Testbench top for the sorted list priority queue: stimulus, timeout and verdict.
`timescale 1ns / 1ps

module sorted_list_priority_queue_tb;
   import slpq_pkg::*;

   localparam int CAPACITY      = 16;
   localparam int RANDOM_OPS    = 500;
   localparam int QUIET_TAIL    = 100;
   localparam int PHASE_LEN     = 40;
   localparam int DRAIN_CYCLES  = 40;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int POOL_SIZE     = 6;

   localparam int MODE_FILL     = 0;
   localparam int MODE_DRAIN    = 1;
   localparam int MODE_MIXED    = 2;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [1:0]                 req_func;
   logic [KEY_PORT_BITS-1:0]   req_key;
   logic                       rsp_valid;
   logic [1:0]                 rsp_status;
   logic [KEY_PORT_BITS-1:0]   rsp_popped_key;
   logic [KEY_PORT_BITS-1:0]   rsp_smallest;
   logic [KEY_PORT_BITS-1:0]   rsp_largest;
   logic [COUNT_PORT_BITS-1:0] rsp_count;
   logic                       rsp_is_empty;
   int                         fail_count;
   int                         outstanding;
   int                         cycle_count;

   logic [KEY_PORT_BITS-1:0]   key_pool [POOL_SIZE];

   sorted_list_priority_queue #(
      .CAPACITY(CAPACITY),
      .KEY_BITS(KEY_PORT_BITS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_popped_key (rsp_popped_key),
      .rsp_smallest   (rsp_smallest),
      .rsp_largest    (rsp_largest),
      .rsp_count      (rsp_count),
      .rsp_is_empty   (rsp_is_empty)
   );

   slpq_checker #(
      .CAPACITY(CAPACITY)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_popped_key (rsp_popped_key),
      .rsp_smallest   (rsp_smallest),
      .rsp_largest    (rsp_largest),
      .rsp_count      (rsp_count),
      .rsp_is_empty   (rsp_is_empty),
      .fail_count     (fail_count),
      .outstanding    (outstanding)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the transaction is taken
   task automatic issue_op(input logic [1:0] func, input logic [KEY_PORT_BITS-1:0] key);
      logic taken;
      req_func <= func;
      req_key  <= key;
      start    <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
      end
      @(negedge clock);
   endtask

   task automatic pause_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   function automatic logic [1:0] pick_func(input int mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_FILL:  return r < 75 ? OP_INSERT : r < 85 ? OP_ERASE : r < 97 ? OP_POP : OP_UNUSED;
         MODE_DRAIN: return r < 20 ? OP_INSERT : r < 55 ? OP_ERASE : r < 97 ? OP_POP : OP_UNUSED;
         default:    return r < 40 ? OP_INSERT : r < 70 ? OP_ERASE : r < 97 ? OP_POP : OP_UNUSED;
      endcase
   endfunction

   initial begin
      int mode;
      int n;
      logic [KEY_PORT_BITS-1:0] key;

      reset    = 1'b1;
      start    = 1'b0;
      req_func = OP_INSERT;
      req_key  = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty-list cases, extremes, duplicates, one-entry erase, misses
      issue_op(OP_POP,    16'h0000);
      issue_op(OP_ERASE,  16'h0000);
      issue_op(OP_UNUSED, 16'hFFFF);
      issue_op(OP_INSERT, 16'hFFFF);
      issue_op(OP_ERASE,  16'hFFFF);
      issue_op(OP_INSERT, 16'h0000);
      issue_op(OP_INSERT, 16'hFFFF);
      issue_op(OP_INSERT, 16'h0000);
      issue_op(OP_INSERT, 16'h8000);
      issue_op(OP_INSERT, 16'h5555);
      issue_op(OP_INSERT, 16'hAAAA);
      issue_op(OP_ERASE,  16'h1234);
      issue_op(OP_ERASE,  16'h0000);
      issue_op(OP_UNUSED, 16'h0000);
      issue_op(OP_POP,    16'hFFFF);
      issue_op(OP_POP,    16'h0000);
      issue_op(OP_INSERT, 16'hAAAA);
      issue_op(OP_ERASE,  16'hFFFF);
      issue_op(OP_INSERT, 16'h0001);
      issue_op(OP_INSERT, 16'h7FFF);
      issue_op(OP_ERASE,  16'hAAAA);

      // random: phases lean towards filling or draining so full and empty both recur
      mode = MODE_MIXED;
      for (n = 0; n < RANDOM_OPS; n++) begin
         if (n % PHASE_LEN == 0) begin
            mode = $urandom_range(MODE_FILL, MODE_MIXED);
            key_pool[0] = 16'h0000;
            key_pool[1] = 16'hFFFF;
            for (int p = 2; p < POOL_SIZE; p++) key_pool[p] = KEY_PORT_BITS'($urandom);
         end
         // small pool so erases mostly hit and duplicates pile up
         if ($urandom_range(0, 1)) key = key_pool[$urandom_range(0, POOL_SIZE-1)];
         else key = KEY_PORT_BITS'($urandom);
         issue_op(pick_func(mode), key);
         if (n < RANDOM_OPS - QUIET_TAIL && $urandom_range(0, 9) < 3)
            pause_cycles($urandom_range(1, 12));
      end
      start <= 1'b0;

      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/slpq_pkg.sv
hw/rtl/slpq_ram.sv
hw/rtl/sorted_list_priority_queue.sv
bench/slpq_checker.sv
bench/sorted_list_priority_queue_tb.sv
